### rtl/tlpte_pkg.sv
// Shared constants, codes and control/status bundles of the page table engine.
package tlpte_pkg;

  // Default sizes of the directory set and the table pool.
  localparam int NUM_DIRS_DEF    = 4;
  localparam int TABLE_SLOTS_DEF = 16;

  // Fixed 10/10/12 address split.
  localparam int IDX_W       = 10;
  localparam int OFF_W       = 12;
  localparam int FRAME_W     = 32 - OFF_W;
  localparam int TBL_ENTRIES = 1024;
  localparam int DIR_SHIFT   = 22;
  localparam int TBL_SHIFT   = 12;

  // Operation codes carried on func_i; code 3 is unused.
  localparam logic [1:0] FUNC_MAP    = 2'd0;
  localparam logic [1:0] FUNC_UNMAP  = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic exec;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_lookup;
  } stat_t;

endpackage

### rtl/two_level_page_table_engine_unit.sv
// Top level of the two-level page table engine.
//
// Usage: drive func_i, dir_sel_i, virt_addr_i, phys_addr_i and entry_flags_i
// and raise start; the beat is taken at a clock edge where busy is low.
// Each beat yields exactly one result beat, shown for one cycle with done_o
// high on status_o, phys_out_o, flags_out_o and present_o. The receiver
// cannot hold results off; it must take them in that cycle.
// Map, unmap and the unused code give done_o after the execute state, and
// lookup after a further lookup state, since a lookup reads the directory
// memory and then the table memory, each with a registered read port. A new
// beat can be taken in the cycle that done_o shows, and not before it.
// After reset the block sweeps both memories to zero, one entry a cycle, over
// max(NUM_DIRS, TABLE_SLOTS) * 1024 entries (16384 with the defaults); busy
// stays high until the sweep ends. Tables are handed out in order and never
// freed.
module two_level_page_table_engine_unit #(
  parameter int NUM_DIRS    = tlpte_pkg::NUM_DIRS_DEF,
  parameter int TABLE_SLOTS = tlpte_pkg::TABLE_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [1:0]  dir_sel_i,
  input  logic [31:0] virt_addr_i,
  input  logic [31:0] phys_addr_i,
  input  logic [11:0] entry_flags_i,
  output logic        done_o,
  output logic        status_o,
  output logic [31:0] phys_out_o,
  output logic [11:0] flags_out_o,
  output logic        present_o
);

  tlpte_pkg::cmd_t  cmd;
  tlpte_pkg::stat_t stat;

  // Sequencer.
  tlpte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Memories and result registers.
  tlpte_dpath #(
    .NUM_DIRS    (NUM_DIRS),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .func_i        (func_i),
    .dir_sel_i     (dir_sel_i),
    .virt_addr_i   (virt_addr_i),
    .phys_addr_i   (phys_addr_i),
    .entry_flags_i (entry_flags_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .phys_out_o    (phys_out_o),
    .flags_out_o   (flags_out_o),
    .present_o     (present_o)
  );

`ifndef SYNTHESIS
  // A result beat lasts a single cycle.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");

  // An accepted beat keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy low right after accept");

  // Once the execute state has passed, the result is out or a lookup is still running.
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 (done_o || busy)) else $error("operation stalled");

  // A result appears only when the block is ready again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
`endif

endmodule

### rtl/tlpte_ctrl.sv
// Controller state machine of the page table engine.
module tlpte_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  tlpte_pkg::stat_t stat_i,
  output tlpte_pkg::cmd_t  cmd_o,
  output logic            busy
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_EXEC   = 4'b0100,
    ST_LOOKUP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.is_lookup ? ST_LOOKUP : ST_IDLE;
      end
      ST_LOOKUP: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

### rtl/tlpte_dpath.sv
// Datapath of the page table engine: directory and table memories, slot counter, result.
module tlpte_dpath #(
  parameter int NUM_DIRS    = tlpte_pkg::NUM_DIRS_DEF,
  parameter int TABLE_SLOTS = tlpte_pkg::TABLE_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlpte_pkg::cmd_t  cmd_i,
  output tlpte_pkg::stat_t stat_o,
  input  logic [1:0]       func_i,
  input  logic [1:0]       dir_sel_i,
  input  logic [31:0]      virt_addr_i,
  input  logic [31:0]      phys_addr_i,
  input  logic [11:0]      entry_flags_i,
  output logic             done_o,
  output logic             status_o,
  output logic [31:0]      phys_out_o,
  output logic [11:0]      flags_out_o,
  output logic             present_o
);

  localparam int IDX_W     = tlpte_pkg::IDX_W;
  localparam int OFF_W     = tlpte_pkg::OFF_W;
  localparam int FRAME_W   = tlpte_pkg::FRAME_W;
  localparam int SLOT_W    = $clog2(TABLE_SLOTS + 1);
  localparam int SIDX_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int DSEL_W    = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1;
  localparam int DIR_DEPTH = NUM_DIRS * tlpte_pkg::TBL_ENTRIES;
  localparam int DIR_AW    = DSEL_W + IDX_W;
  localparam int TBL_DEPTH = TABLE_SLOTS * tlpte_pkg::TBL_ENTRIES;
  localparam int TBL_AW    = SIDX_W + IDX_W;
  localparam int CLR_DEPTH = (DIR_DEPTH > TBL_DEPTH) ? DIR_DEPTH : TBL_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  // Memories: directory entries hold table slot plus one, zero when absent.
  logic [SLOT_W-1:0] dir_mem [DIR_DEPTH];
  logic [31:0]       tbl_mem [TBL_DEPTH];

  // Captured operation.
  logic [1:0]         func_q;
  logic [1:0]         dir_sel_q;
  logic [31:0]        virt_q;
  logic [FRAME_W-1:0] frame_q;
  logic [OFF_W-1:0]   eflags_q;

  // Read data, slot counter, clear sweep and result registers.
  logic [SLOT_W-1:0]  dir_rd_q;
  logic [31:0]        tbl_rd_q;
  logic               hit_q;
  logic [SLOT_W-1:0]  next_free_q;
  logic [CLR_W-1:0]   clr_q;
  logic               done_q;
  logic               status_q;
  logic [31:0]        phys_q;
  logic [OFF_W-1:0]   flout_q;
  logic               present_q;

  logic [DIR_AW-1:0]  dir_rd_addr;
  logic               dir_ok;
  logic               have_tbl;
  logic               can_alloc;
  logic               is_map;
  logic               is_unmap;
  logic               is_lookup;
  logic               map_fail;
  logic               alloc;
  logic [SIDX_W-1:0]  slot_idx;
  logic [TBL_AW-1:0]  tbl_addr;
  logic               clr_dir;
  logic               clr_tbl;
  logic               dir_we;
  logic [DIR_AW-1:0]  dir_wa;
  logic [SLOT_W-1:0]  dir_wd;
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_wa;
  logic [31:0]        tbl_wd;
  logic               lk_present;

  // Directory read address straight from the ports on the accept cycle.
  assign dir_rd_addr = DIR_AW'({dir_sel_i, virt_addr_i[31:tlpte_pkg::DIR_SHIFT]});

  // Decode of the captured operation against the directory entry just read.
  assign is_map    = (func_q == tlpte_pkg::FUNC_MAP);
  assign is_unmap  = (func_q == tlpte_pkg::FUNC_UNMAP);
  assign is_lookup = (func_q == tlpte_pkg::FUNC_LOOKUP);
  assign dir_ok    = (5'(dir_sel_q) < 5'(NUM_DIRS));
  assign have_tbl  = dir_ok && (dir_rd_q != '0);
  assign can_alloc = (next_free_q < SLOT_W'(TABLE_SLOTS));
  assign map_fail  = is_map && (!dir_ok || (!have_tbl && !can_alloc));
  assign alloc     = cmd_i.exec && is_map && dir_ok && !have_tbl && can_alloc;
  assign slot_idx  = have_tbl ? SIDX_W'(dir_rd_q - SLOT_W'(1)) : SIDX_W'(next_free_q);
  assign tbl_addr  = TBL_AW'({slot_idx, virt_q[tlpte_pkg::TBL_SHIFT +: IDX_W]});

  // The clearing sweep covers whichever memory is deeper.
  assign clr_dir = cmd_i.clear_en && ((CLR_W + 1)'(clr_q) < (CLR_W + 1)'(DIR_DEPTH));
  assign clr_tbl = cmd_i.clear_en && ((CLR_W + 1)'(clr_q) < (CLR_W + 1)'(TBL_DEPTH));

  // Write port selection for both memories.
  always_comb begin
    if (cmd_i.clear_en) begin
      dir_we = clr_dir;
      dir_wa = DIR_AW'(clr_q);
      dir_wd = '0;
      tbl_we = clr_tbl;
      tbl_wa = TBL_AW'(clr_q);
      tbl_wd = '0;
    end else begin
      dir_we = alloc;
      dir_wa = DIR_AW'({dir_sel_q, virt_q[31:tlpte_pkg::DIR_SHIFT]});
      dir_wd = next_free_q + SLOT_W'(1);
      tbl_we = cmd_i.exec && ((is_map && !map_fail) || (is_unmap && have_tbl));
      tbl_wa = tbl_addr;
      tbl_wd = is_map ? {frame_q, eflags_q} : '0;
    end
  end

  // Directory memory.
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    if (cmd_i.capture) begin
      dir_rd_q <= dir_mem[dir_rd_addr];
    end
  end

  // Table memory.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (cmd_i.exec && is_lookup) begin
      tbl_rd_q <= tbl_mem[tbl_addr];
    end
  end

  // Operation capture and lookup hit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q    <= func_i;
      dir_sel_q <= dir_sel_i;
      virt_q    <= virt_addr_i;
      frame_q   <= phys_addr_i[31:OFF_W];
      eflags_q  <= entry_flags_i;
    end
    if (cmd_i.exec) begin
      hit_q <= have_tbl;
    end
  end

  // Slot counter, clear sweep and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= '0;
      clr_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      if (alloc) begin
        next_free_q <= next_free_q + SLOT_W'(1);
      end
      if (cmd_i.clear_en) begin
        clr_q <= clr_q + CLR_W'(1);
      end
      done_q <= (cmd_i.exec && !is_lookup) || cmd_i.finish;
    end
  end

  assign lk_present = hit_q && tbl_rd_q[0];

  // Result beat: map, unmap and unused codes finish in the execute cycle, lookups in the finish cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && !is_lookup) begin
      status_q  <= map_fail;
      phys_q    <= '0;
      flout_q   <= '0;
      present_q <= 1'b0;
    end else if (cmd_i.finish) begin
      status_q  <= 1'b0;
      phys_q    <= lk_present ? {tbl_rd_q[31:OFF_W], virt_q[OFF_W-1:0]} : '0;
      flout_q   <= hit_q ? tbl_rd_q[OFF_W-1:0] : '0;
      present_q <= lk_present;
    end
  end

  assign stat_o.clear_last = (clr_q == CLR_W'(CLR_DEPTH - 1));
  assign stat_o.is_lookup  = is_lookup;

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign phys_out_o  = phys_q;
  assign flags_out_o = flout_q;
  assign present_o   = present_q;

endmodule

### verif/testbench.sv
// Self-checking testbench for the two-level page table engine: map, unmap and lookup beats.
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_DIRS    = tlpte_pkg::NUM_DIRS_DEF;
  localparam int TABLE_SLOTS = tlpte_pkg::TABLE_SLOTS_DEF;
  localparam int TBL_ENTRIES = tlpte_pkg::TBL_ENTRIES;
  localparam int OFF_W       = tlpte_pkg::OFF_W;
  localparam int DIR_SHIFT   = tlpte_pkg::DIR_SHIFT;
  localparam int TBL_SHIFT   = tlpte_pkg::TBL_SHIFT;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  // The clearing sweep after reset alone passes with no beat moving.
  localparam int QUIET_LIMIT   = 60000;
  localparam int ITEMS_PER_PHASE = 475;
  localparam int DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  dir;
    logic [31:0] va;
    logic [31:0] pa;
    logic [11:0] flags;
  } page_op_t;

  typedef struct packed {
    logic        status;
    logic [31:0] phys;
    logic [11:0] flags;
    logic        present;
  } xlate_t;

  typedef struct packed {
    logic [1:0] dir;
    logic [9:0] pd;
  } dir_key_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = '0;
  logic [1:0]  dir_sel_i = '0;
  logic [31:0] virt_addr_i = '0;
  logic [31:0] phys_addr_i = '0;
  logic [11:0] entry_flags_i = '0;
  logic        done_o;
  logic        status_o;
  logic [31:0] phys_out_o;
  logic [11:0] flags_out_o;
  logic        present_o;

  // Shadow copy of the engine state.
  logic [4:0]  dir_slot [NUM_DIRS * TBL_ENTRIES];
  logic [31:0] pte_mem [TABLE_SLOTS * TBL_ENTRIES];
  int unsigned slots_used;

  page_op_t op_q[$];
  xlate_t   xlate_q[$];
  dir_key_t owned_keys[$];
  int       idle_pct = 7;
  int       err_cnt = 0;
  int       quiet_cycles = 0;
  logic     beat_ok = 1'b0;

  two_level_page_table_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .dir_sel_i     (dir_sel_i),
    .virt_addr_i   (virt_addr_i),
    .phys_addr_i   (phys_addr_i),
    .entry_flags_i (entry_flags_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .phys_out_o    (phys_out_o),
    .flags_out_o   (flags_out_o),
    .present_o     (present_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walk the shadow tables for one operation and apply its side effects.
  function automatic xlate_t walk_page_op(page_op_t op);
    xlate_t      res;
    logic [9:0]  pd;
    logic [9:0]  pt;
    logic [4:0]  slot1;
    logic [31:0] pte;
    int          di;
    int          ti;
    res   = '0;
    pd    = op.va[31:DIR_SHIFT];
    pt    = op.va[DIR_SHIFT-1:TBL_SHIFT];
    di    = int'(op.dir) * TBL_ENTRIES + int'(pd);
    slot1 = (int'(op.dir) < NUM_DIRS) ? dir_slot[di] : 5'd0;
    ti    = (int'(slot1) - 1) * TBL_ENTRIES + int'(pt);
    case (op.func)
      tlpte_pkg::FUNC_MAP: begin
        if (int'(op.dir) >= NUM_DIRS) begin
          res.status = 1'b1;
        end else begin
          if (slot1 == 0 && slots_used < TABLE_SLOTS) begin
            slots_used++;
            slot1 = 5'(slots_used);
            dir_slot[di] = slot1;
            ti = (int'(slot1) - 1) * TBL_ENTRIES + int'(pt);
          end
          if (slot1 == 0) res.status = 1'b1;
          else pte_mem[ti] = {op.pa[31:OFF_W], op.flags};
        end
      end
      tlpte_pkg::FUNC_UNMAP: begin
        if (slot1 != 0) pte_mem[ti] = '0;
      end
      tlpte_pkg::FUNC_LOOKUP: begin
        if (slot1 != 0) begin
          pte = pte_mem[ti];
          res.flags = pte[OFF_W-1:0];
          if (pte[0]) begin
            res.present = 1'b1;
            res.phys = {pte[31:OFF_W], op.va[OFF_W-1:0]};
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Queue one operation; remember directory entries that a map will claim while the
  // pool still has room, so the random part can aim at tables that exist.
  task automatic queue_op(logic [1:0] func, logic [1:0] dir, logic [31:0] va,
                          logic [31:0] pa, logic [11:0] flags);
    page_op_t op;
    dir_key_t key;
    bit       known;
    op = '{func: func, dir: dir, va: va, pa: pa, flags: flags};
    key = '{dir: dir, pd: va[31:DIR_SHIFT]};
    known = 1'b0;
    foreach (owned_keys[k]) if (owned_keys[k] == key) known = 1'b1;
    if (func == tlpte_pkg::FUNC_MAP && !known && owned_keys.size() < TABLE_SLOTS)
      owned_keys.push_back(key);
    op_q.push_back(op);
  endtask

  // Mostly well-formed traffic on tables that exist, with a share of raw noise.
  task automatic queue_random_ops(int count);
    dir_key_t   key;
    logic [1:0] func;
    logic [11:0] flags;
    int         pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20 || owned_keys.size() == 0) begin
        queue_op(2'($urandom), 2'($urandom), $urandom, $urandom, 12'($urandom));
      end else begin
        key = owned_keys[$urandom_range(owned_keys.size() - 1)];
        pick = $urandom_range(99);
        if (pick < 35) func = tlpte_pkg::FUNC_MAP;
        else if (pick < 50) func = tlpte_pkg::FUNC_UNMAP;
        else if (pick < 95) func = tlpte_pkg::FUNC_LOOKUP;
        else func = FUNC_SPARE;
        flags = 12'($urandom);
        if ($urandom_range(3) != 0) flags[0] = 1'b1;
        queue_op(func, key.dir, {key.pd, 10'($urandom_range(7)), 12'($urandom)},
                 $urandom, flags);
      end
    end
  endtask

  // Hold the sender until every queued beat has gone and every result has come.
  task automatic drain;
    while (op_q.size() != 0 || start || xlate_q.size() != 0) @(posedge clk_i);
  endtask

  // Sender: a new beat goes up only once the previous one was taken.
  always @(negedge clk_i) begin
    page_op_t op;
    if (rst_ni && (!start || beat_ok)) begin
      if (op_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        op = op_q.pop_front();
        start         <= 1'b1;
        func_i        <= op.func;
        dir_sel_i     <= op.dir;
        virt_addr_i   <= op.va;
        phys_addr_i   <= op.pa;
        entry_flags_i <= op.flags;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Receiver: check the result beat, then record what an accepted beat must yield.
  always @(posedge clk_i) begin
    xlate_t want;
    beat_ok = rst_ni && start && !busy;
    if (rst_ni && done_o) begin
      if (xlate_q.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(status_o), '0);
      end else begin
        want = xlate_q.pop_front();
        if (status_o !== want.status)
          report_mismatch("status_o", 32'(status_o), 32'(want.status));
        if (phys_out_o !== want.phys)
          report_mismatch("phys_out_o", phys_out_o, want.phys);
        if (flags_out_o !== want.flags)
          report_mismatch("flags_out_o", 32'(flags_out_o), 32'(want.flags));
        if (present_o !== want.present)
          report_mismatch("present_o", 32'(present_o), 32'(want.present));
      end
    end
    if (beat_ok)
      xlate_q.push_back(walk_page_op('{func: func_i, dir: dir_sel_i, va: virt_addr_i,
                                       pa: phys_addr_i, flags: entry_flags_i}));
  end

  // Watchdog on cycles in which no beat moves either way.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o === 1'b1) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    foreach (dir_slot[i]) dir_slot[i] = '0;
    foreach (pte_mem[i]) pte_mem[i] = '0;
    slots_used = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, absent tables, a page without its present bit,
    // unmap with and without a table, the unused code, and pool exhaustion.
    queue_op(tlpte_pkg::FUNC_LOOKUP, 2'd0, 32'h0000_0000, 32'h0, 12'h000);
    queue_op(tlpte_pkg::FUNC_MAP,    2'd0, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    queue_op(tlpte_pkg::FUNC_LOOKUP, 2'd0, 32'h0000_0FFF, 32'h0, 12'h000);
    queue_op(tlpte_pkg::FUNC_MAP,    2'd3, 32'hFFFF_FFFF, 32'h1234_5678, 12'h001);
    queue_op(tlpte_pkg::FUNC_LOOKUP, 2'd3, 32'hFFFF_FABC, 32'hFFFF_FFFF, 12'hFFF);
    queue_op(tlpte_pkg::FUNC_MAP,    2'd1, 32'hFFC0_0000, 32'hABCD_E000, 12'h0FE);
    queue_op(tlpte_pkg::FUNC_LOOKUP, 2'd1, 32'hFFC0_0123, 32'h0, 12'h000);
    queue_op(tlpte_pkg::FUNC_LOOKUP, 2'd1, 32'hFFC0_1000, 32'h0, 12'h000);
    queue_op(tlpte_pkg::FUNC_UNMAP,  2'd0, 32'h0000_0000, 32'h0, 12'h000);
    queue_op(tlpte_pkg::FUNC_LOOKUP, 2'd0, 32'h0000_0800, 32'h0, 12'h000);
    queue_op(tlpte_pkg::FUNC_UNMAP,  2'd2, 32'h1234_5678, 32'hFFFF_FFFF, 12'hFFF);
    queue_op(FUNC_SPARE,             2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    for (int k = 0; k < TABLE_SLOTS - 3; k++)
      queue_op(tlpte_pkg::FUNC_MAP, 2'd2, {10'(k), 10'(k), 12'h0},
               {20'(k * 4099), 12'h0}, 12'h001 | 12'(k << 1));
    queue_op(tlpte_pkg::FUNC_MAP,    2'd2, 32'h5540_0000, 32'h8000_0000, 12'h001);
    queue_op(tlpte_pkg::FUNC_LOOKUP, 2'd2, 32'h5540_0000, 32'h0, 12'h000);

    // Three random phases: sender idles rarely, then often, then never.
    queue_random_ops(ITEMS_PER_PHASE);
    drain();
    idle_pct = 73;
    queue_random_ops(ITEMS_PER_PHASE);
    drain();
    idle_pct = 0;
    queue_random_ops(ITEMS_PER_PHASE);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
